// ----- hw/rtl/hndm_pkg.sv -----
// ----------------------------------------------------------------------------
// hndm_pkg
// Types and constants shared by the Hamming nearest descriptor match core.
// ----------------------------------------------------------------------------
package hndm_pkg;

  localparam int NUM_LANES  = 4;
  localparam int WORD_W     = 64;
  localparam int POP_W      = 7;   // 0..64
  localparam int DIST_W     = 9;   // 0..256 distance, 0..511 register
  localparam int MIDX_W     = 10;
  localparam int CFG_ADDR_W = 2;

  localparam logic [DIST_W-1:0] START_DIST_RST = 9'd128;
  localparam logic [DIST_W-1:0] ACCEPT_THR_RST = 9'd80;

  localparam logic [CFG_ADDR_W-1:0] REG_START_DIST = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACCEPT_THR = 2'd1;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [WORD_W-1:0] desc_word0;
    logic [WORD_W-1:0] desc_word1;
    logic [WORD_W-1:0] desc_word2;
    logic [WORD_W-1:0] desc_word3;
  } in_word_t;

  typedef struct packed {
    logic              match_found;
    logic [MIDX_W-1:0] match_index;
    logic [DIST_W-1:0] match_distance;
    logic              entries_dropped;
  } out_word_t;

  typedef logic [NUM_LANES-1:0][POP_W-1:0] lane_pops_t;

  typedef struct packed {
    logic init;  // restart the best-so-far search
    logic beat;  // lane counts are valid this cycle
  } merge_ctl_t;

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + {3'd0, b[i]};
    end
    return s;
  endfunction

  function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] x);
    logic [POP_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + {3'd0, pop8(x[i*8 +: 8])};
    end
    return s;
  endfunction

endpackage

// ----- hw/rtl/hamming_nearest_descriptor_match_core.sv -----
// ----------------------------------------------------------------------------
// hamming_nearest_descriptor_match_core
// Brute-force nearest neighbor search over stored 256-bit binary descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per command. func selects clear, append or query; the
//           four desc_word fields carry the 256-bit descriptor.
//   out_* : one result word per query only; clear and append produce none.
//   cfg_* : write start distance (index 0) or accept threshold (index 1)
//           while the core is idle. Other indexes are ignored.
// Timing:
//   Clear and append are taken in the idle state. A query reads one stored entry
//   per cycle across four 64-bit lanes (one RAM read port per lane); each read
//   passes the RAM read register, the lane popcount register and the merge
//   register before the result is loaded into the output register, and no new
//   word is taken until then. in_ready is low while a query scans or holds.
// Reset clears the table count, the overflow flag and the output valid and
// loads the register defaults (start 128, threshold 80). If the receiver
// stalls, the result stays in the output register and commands keep being
// taken; a query that finishes meanwhile holds until the register frees.
// ----------------------------------------------------------------------------
module hamming_nearest_descriptor_match_core #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hndm_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hndm_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [hndm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hndm_pkg::DIST_W-1:0]     cfg_wdata
);
  import hndm_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_ENTRIES);

  state_t state_r, state_nxt;

  logic [DIST_W-1:0] start_dist_r, accept_thr_r;
  logic [CNT_W-1:0]  count_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic              v1_r, v2_r;
  logic [IDX_W-1:0]  idx1_r, idx2_r;
  in_word_t          q_r;
  out_word_t         out_r;
  logic              out_valid_r;

  logic in_fire, is_query, is_append, is_clear, room;
  logic issue_go, scan_done, out_free;
  logic out_load, ram_we;

  merge_ctl_t        mctl;
  lane_pops_t        pops;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;
  logic              chosen;
  logic [IDX_W+MIDX_W-1:0] idx_ext;

  logic [NUM_LANES-1:0][WORD_W-1:0] wr_words, q_words;

  assign in_fire   = in_valid && in_ready;
  assign is_clear  = (in_data.func == FUNC_CLEAR);
  assign is_append = (in_data.func == FUNC_APPEND);
  assign is_query  = (in_data.func == FUNC_QUERY);
  assign room      = (count_r < CAPACITY);
  assign issue_go  = (rd_idx_r < count_r);
  assign scan_done = !issue_go && !v1_r && !v2_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && is_query) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: out_load = scan_done && out_free;
      ST_HOLD: out_load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  assign ram_we    = in_fire && is_append && room;
  assign mctl.init = in_fire && is_query;
  assign mctl.beat = v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      start_dist_r <= START_DIST_RST;
      accept_thr_r <= ACCEPT_THR_RST;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      rd_idx_r     <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_START_DIST: start_dist_r <= cfg_wdata;
          REG_ACCEPT_THR: accept_thr_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        if (is_clear) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end else if (is_append) begin
          if (room) begin
            count_r <= count_r + 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
        end
      end
      if (in_fire && is_query) begin
        rd_idx_r <= '0;
      end else if (state_r == ST_SCAN && issue_go) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      v1_r <= (state_r == ST_SCAN) && issue_go;
      v2_r <= v1_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign idx_ext = {{MIDX_W{1'b0}}, best_idx};

  always_ff @(posedge clk) begin
    if (in_fire && is_query) begin
      q_r <= in_data;
    end
    idx1_r <= rd_idx_r[IDX_W-1:0];
    idx2_r <= idx1_r;
    if (out_load) begin
      out_r.match_found     <= chosen && (best_dist < accept_thr_r);
      out_r.match_index     <= idx_ext[MIDX_W-1:0];
      out_r.match_distance  <= best_dist;
      out_r.entries_dropped <= ovf_r;
    end
  end

  assign wr_words = {in_data.desc_word3, in_data.desc_word2,
                     in_data.desc_word1, in_data.desc_word0};
  assign q_words  = {q_r.desc_word3, q_r.desc_word2,
                     q_r.desc_word1, q_r.desc_word0};

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    hndm_lane #(
      .ENTRIES (MAX_ENTRIES),
      .IDX_W   (IDX_W)
    ) u_lane (
      .clk      (clk),
      .wr_en    (ram_we),
      .wr_addr  (count_r[IDX_W-1:0]),
      .wr_data  (wr_words[g]),
      .rd_addr  (rd_idx_r[IDX_W-1:0]),
      .qry_word (q_words[g]),
      .pop      (pops[g])
    );
  end

  hndm_merge #(
    .ENTRIES (MAX_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_merge (
    .clk        (clk),
    .ctl        (mctl),
    .start_dist (start_dist_r),
    .pops       (pops),
    .beat_idx   (idx2_r),
    .best_dist  (best_dist),
    .best_idx   (best_idx),
    .chosen     (chosen)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hw/rtl/hndm_ram.sv -----
// ----------------------------------------------------------------------------
// hndm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hndm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/hndm_lane.sv -----
// ----------------------------------------------------------------------------
// hndm_lane
// One 64-bit slice of the descriptor store with its XOR and popcount stage.
// ----------------------------------------------------------------------------
module hndm_lane #(
  parameter int ENTRIES = 1024,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [hndm_pkg::WORD_W-1:0] wr_data,
  input  logic [IDX_W-1:0]           rd_addr,
  input  logic [hndm_pkg::WORD_W-1:0] qry_word,
  output logic [hndm_pkg::POP_W-1:0]  pop
);
  import hndm_pkg::*;

  logic [WORD_W-1:0] rd_data;
  logic [POP_W-1:0]  pop_r;

  hndm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    pop_r <= pop64(rd_data ^ qry_word);
  end

  assign pop = pop_r;

endmodule

// ----- hw/rtl/hndm_merge.sv -----
// ----------------------------------------------------------------------------
// hndm_merge
// Adds the lane counts into one distance and keeps the first strict minimum.
// ----------------------------------------------------------------------------
module hndm_merge #(
  parameter int ENTRIES = 1024,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                        clk,
  input  hndm_pkg::merge_ctl_t        ctl,
  input  logic [hndm_pkg::DIST_W-1:0] start_dist,
  input  hndm_pkg::lane_pops_t        pops,
  input  logic [IDX_W-1:0]            beat_idx,
  output logic [hndm_pkg::DIST_W-1:0] best_dist,
  output logic [IDX_W-1:0]            best_idx,
  output logic                        chosen
);
  import hndm_pkg::*;

  logic [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              chosen_r, chosen_nxt;

  always_comb begin
    dist_sum = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      dist_sum = dist_sum + {{(DIST_W-POP_W){1'b0}}, pops[i]};
    end
  end

  always_comb begin
    best_nxt   = best_r;
    idx_nxt    = idx_r;
    chosen_nxt = chosen_r;
    if (ctl.init) begin
      best_nxt   = start_dist;
      idx_nxt    = '0;
      chosen_nxt = 1'b0;
    end else if (ctl.beat && (dist_sum < best_r)) begin
      // strict compare keeps the first of equal distances
      best_nxt   = dist_sum;
      idx_nxt    = beat_idx;
      chosen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    best_r   <= best_nxt;
    idx_r    <= idx_nxt;
    chosen_r <= chosen_nxt;
  end

  assign best_dist = best_r;
  assign best_idx  = idx_r;
  assign chosen    = chosen_r;

endmodule

// ----- tb/sv/tb_hamming_nearest_descriptor_match_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hamming_nearest_descriptor_match_core
// Self-checking bench for the nearest descriptor match core. A short table of
// directed commands covers the empty table, exact hits, ties, the threshold
// boundary and the unused command code. Random phases follow under several
// register settings, including 0 and 257 for each register. A query without
// a pinned result is scored against an in-bench search over its own table copy.
// ----------------------------------------------------------------------------
module tb_hamming_nearest_descriptor_match_core;
  import hndm_pkg::*;

  localparam int          TABLE_DEPTH = 1024;
  localparam int          SMALL_TABLE = 32;
  localparam int          CYCLE_LIMIT = 600000;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE3 = 2'd3;
  localparam logic [255:0] ZEROS = '0;
  localparam logic [255:0] ONES  = '1;
  localparam logic [255:0] ALT   = {64{4'h5}};
  localparam logic [255:0] PAT   =
    256'h0f1e2d3c4b5a6978_8796a5b4c3d2e1f0_13579bdf02468ace_fdb97531eca86420;

  typedef struct {
    logic [1:0]   func;
    logic [255:0] desc;
    bit           pinned;
    out_word_t    want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DIST_W-1:0]     cfg_wdata;

  // shadow of the block's table and registers
  logic [255:0]      stored_desc [TABLE_DEPTH];
  int unsigned       stored_cnt;
  bit                dropped_flag;
  logic [DIST_W-1:0] cur_start_dist;
  logic [DIST_W-1:0] cur_accept_thr;

  out_word_t pending_matches [$];
  dir_row_t  dir_rows [$];

  bit idle_on = 1'b1;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int stall_left = 0;
  int n_taken = 0;
  int n_queries = 0;
  int n_appends = 0;
  int n_clears = 0;
  int n_results = 0;
  int n_found = 0;
  int n_settings = 0;

  hamming_nearest_descriptor_match_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Apply one command to the shadow table; return 1 with the search result
  // for a query.
  function automatic bit apply_command(input in_word_t w, output out_word_t res);
    logic [255:0]      key;
    logic [DIST_W-1:0] best;
    logic [MIDX_W-1:0] best_idx;
    bit                chosen;
    int unsigned       ham_d;
    key = {w.desc_word3, w.desc_word2, w.desc_word1, w.desc_word0};
    res = '0;
    case (w.func)
      FUNC_CLEAR: begin
        stored_cnt   = 0;
        dropped_flag = 1'b0;
        return 1'b0;
      end
      FUNC_APPEND: begin
        if (stored_cnt < TABLE_DEPTH) begin
          stored_desc[stored_cnt] = key;
          stored_cnt++;
        end else begin
          dropped_flag = 1'b1;
        end
        return 1'b0;
      end
      FUNC_QUERY: begin
        best     = cur_start_dist;
        best_idx = '0;
        chosen   = 1'b0;
        for (int i = 0; i < stored_cnt; i++) begin
          ham_d = $countones(key ^ stored_desc[i]);
          if (ham_d < best) begin
            best     = ham_d[DIST_W-1:0];
            best_idx = i[MIDX_W-1:0];
            chosen   = 1'b1;
          end
        end
        res.match_found     = chosen && (best < cur_accept_thr);
        res.match_index     = best_idx;
        res.match_distance  = best;
        res.entries_dropped = dropped_flag;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void add_row(input logic [1:0] func, input logic [255:0] desc,
                                  input bit pinned, input out_word_t want);
    dir_row_t row;
    row.func   = func;
    row.desc   = desc;
    row.pinned = pinned;
    row.want   = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic in_word_t make_word(input logic [1:0] func, input logic [255:0] d);
    in_word_t w;
    w.func       = func;
    w.desc_word0 = d[63:0];
    w.desc_word1 = d[127:64];
    w.desc_word2 = d[191:128];
    w.desc_word3 = d[255:192];
    return w;
  endfunction

  function automatic logic [255:0] rand_desc();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [255:0] flip_bits(input logic [255:0] d, input int k);
    int pos;
    for (int j = 0; j < k; j++) begin
      pos = $urandom_range(255);
      d[pos] = ~d[pos];
    end
    return d;
  endfunction

  // Send one command word; a pinned row overrides the search result.
  task automatic push_word(input in_word_t w, input bit pinned, input out_word_t pinned_res);
    out_word_t res;
    int        gap;
    gap = 0;
    if (idle_on && $urandom_range(3) == 0) gap = $urandom_range(10, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (apply_command(w, res))
      pending_matches.insert(pending_matches.size(), pinned ? pinned_res : res);
    case (w.func)
      FUNC_CLEAR:  n_clears++;
      FUNC_APPEND: n_appends++;
      FUNC_QUERY:  n_queries++;
      default: ;
    endcase
    if (w.func != FUNC_UNUSED) n_taken++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [DIST_W-1:0] start, input logic [DIST_W-1:0] thr);
    logic [CFG_ADDR_W-1:0] spare;
    drain_results();
    // let a trailing clear or append settle
    repeat (8) @(posedge clk);
    spare = $urandom_range(1) ? REG_SPARE2 : REG_SPARE3;
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_START_DIST;
    cfg_wdata <= start;
    @(posedge clk);
    cur_start_dist = start;
    cfg_addr  <= REG_ACCEPT_THR;
    cfg_wdata <= thr;
    @(posedge clk);
    cur_accept_thr = thr;
    // spare index: the block must ignore it
    cfg_addr  <= spare;
    cfg_wdata <= DIST_W'($urandom_range(511));
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_command();
    logic [255:0] d;
    int           roll;
    int           sel;
    int           pick;
    roll = $urandom_range(99);
    pick = (stored_cnt > 0) ? $urandom_range(stored_cnt - 1) : 0;
    if ($urandom_range(59) == 0) drain_results();
    if (roll < 4) begin
      push_word(make_word(FUNC_CLEAR, rand_desc()), 1'b0, '0);
    end else if (roll < 8) begin
      push_word(make_word(FUNC_UNUSED, rand_desc()), 1'b0, '0);
    end else if (roll < 40) begin
      // keep the table small so scans stay short
      if (stored_cnt >= SMALL_TABLE) begin
        push_word(make_word(FUNC_CLEAR, rand_desc()), 1'b0, '0);
      end else begin
        d = (stored_cnt > 0 && $urandom_range(4) == 0) ? stored_desc[pick] : rand_desc();
        push_word(make_word(FUNC_APPEND, d), 1'b0, '0);
      end
    end else begin
      sel = $urandom_range(99);
      if (stored_cnt == 0 || sel < 10) d = rand_desc();
      else if (sel < 15) d = sel[0] ? ONES : ZEROS;
      else if (sel < 25) d = ~stored_desc[pick];
      else if (sel < 55) d = flip_bits(stored_desc[pick], $urandom_range(8));
      else d = flip_bits(stored_desc[pick], $urandom_range(110, 9));
      push_word(make_word(FUNC_QUERY, d), 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int n_items);
    logic [255:0] d;
    int           goal;
    // open with an entry and its complement: distance 256
    d = rand_desc();
    push_word(make_word(FUNC_CLEAR, rand_desc()), 1'b0, '0);
    push_word(make_word(FUNC_APPEND, d), 1'b0, '0);
    push_word(make_word(FUNC_QUERY, ~d), 1'b0, '0);
    goal = n_taken + n_items;
    while (n_taken < goal) random_command();
  endtask

  // result side: random stall bursts, score every accepted word
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_data.match_found) n_found++;
      if (pending_matches.size() == 0) begin
        $error("result word with no query outstanding");
        fail_cnt++;
      end else begin
        want = pending_matches.pop_front();
        if (out_data.match_found !== want.match_found) begin
          $error("match_found: expected %0d, actual %0d",
                 want.match_found, out_data.match_found);
          fail_cnt++;
        end
        if (out_data.match_index !== want.match_index) begin
          $error("match_index: expected %0d, actual %0d",
                 want.match_index, out_data.match_index);
          fail_cnt++;
        end
        if (out_data.match_distance !== want.match_distance) begin
          $error("match_distance: expected %0d, actual %0d",
                 want.match_distance, out_data.match_distance);
          fail_cnt++;
        end
        if (out_data.entries_dropped !== want.entries_dropped) begin
          $error("entries_dropped: expected %0d, actual %0d",
                 want.entries_dropped, out_data.entries_dropped);
          fail_cnt++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(5) == 0) begin
      stall_left = $urandom_range(9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    stored_cnt     = 0;
    dropped_flag   = 1'b0;
    cur_start_dist = START_DIST_RST;
    cur_accept_thr = ACCEPT_THR_RST;

    add_row(FUNC_QUERY,  ZEROS, 1'b1, out_word_t'{1'b0, 10'd0, 9'd128, 1'b0});
    add_row(FUNC_UNUSED, ONES,  1'b0, '0);
    add_row(FUNC_APPEND, ZEROS, 1'b0, '0);
    add_row(FUNC_APPEND, ONES,  1'b0, '0);
    add_row(FUNC_QUERY,  ZEROS, 1'b1, out_word_t'{1'b1, 10'd0, 9'd0, 1'b0});
    add_row(FUNC_QUERY,  ONES,  1'b1, out_word_t'{1'b1, 10'd1, 9'd0, 1'b0});
    add_row(FUNC_APPEND, ZEROS, 1'b0, '0);
    // tie with a later duplicate: first entry wins
    add_row(FUNC_QUERY,  ZEROS, 1'b1, out_word_t'{1'b1, 10'd0, 9'd0, 1'b0});
    // every entry exactly at the start distance: nothing chosen
    add_row(FUNC_QUERY,  ALT,   1'b1, out_word_t'{1'b0, 10'd0, 9'd128, 1'b0});
    add_row(FUNC_QUERY,  ONES >> 192, 1'b1, out_word_t'{1'b1, 10'd0, 9'd64, 1'b0});
    // threshold boundary: 80 is chosen but not accepted, 79 is accepted
    add_row(FUNC_QUERY,  ONES >> 176, 1'b1, out_word_t'{1'b0, 10'd0, 9'd80, 1'b0});
    add_row(FUNC_QUERY,  ONES >> 177, 1'b1, out_word_t'{1'b1, 10'd0, 9'd79, 1'b0});
    add_row(FUNC_QUERY,  ONES >> 56, 1'b1, out_word_t'{1'b1, 10'd1, 9'd56, 1'b0});
    add_row(FUNC_UNUSED, ZEROS, 1'b0, '0);
    add_row(FUNC_APPEND, PAT,   1'b0, '0);
    add_row(FUNC_QUERY,  PAT ^ 256'h8000_0001_0000_0000_0000_0011, 1'b0, '0);
    add_row(FUNC_QUERY,  ~PAT,  1'b0, '0);
    add_row(FUNC_CLEAR,  ONES,  1'b0, '0);
    add_row(FUNC_QUERY,  PAT,   1'b1, out_word_t'{1'b0, 10'd0, 9'd128, 1'b0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r])
      push_word(make_word(dir_rows[r].func, dir_rows[r].desc), dir_rows[r].pinned,
                dir_rows[r].want);

    write_regs(9'd257, 9'd257);
    run_phase(70);
    write_regs(9'd0, 9'd0);
    run_phase(60);
    write_regs(9'd257, 9'd0);
    run_phase(60);
    write_regs(9'd0, 9'd257);
    run_phase(60);
    write_regs(9'd256, 9'd255);
    run_phase(70);

    write_regs(START_DIST_RST, ACCEPT_THR_RST);
    run_phase(60);
    write_regs(DIST_W'($urandom_range(257)), DIST_W'($urandom_range(257)));
    run_phase(70);
    // last stretch at full rate on both sides
    write_regs(DIST_W'($urandom_range(257, 100)), DIST_W'($urandom_range(257, 60)));
    idle_on = 1'b0;
    run_phase(70);

    drain_results();
    repeat (1100) @(posedge clk);
    $display("Covered %0d queries, %0d appends and %0d clears under %0d register settings,",
             n_queries, n_appends, n_clears, n_settings + 1);
    $display("with the register extremes; %0d results scored, %0d of them matches.",
             n_results, n_found);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
